// ===== rtl/core/bte_pkg.sv =====
`default_nettype none
package bte_pkg;

   localparam int PIN_W  = 5;
   localparam int WORD_W = 32;
   localparam int KIND_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int OPQ_DEPTH = 4;
   localparam int OPQ_PTR_W = 2;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT     = 2'd2;

   // event kinds on the response channel
   localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HELD    = 2'd2;

   typedef enum logic [2:0] {
      OP_PRESS,
      OP_RELEASE,
      OP_STORE,
      OP_HELD,
      OP_END
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [PIN_W-1:0]  pin;
      logic [WORD_W-1:0] tick;
   } op_type;

   typedef struct packed {
      logic [WORD_W-1:0] enable;
      logic [WORD_W-1:0] active_low;
      logic [WORD_W-1:0] report;
   } cfg_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_WALK,
      FE_END
   } fe_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_EMIT
   } bk_state_type;

endpackage
`default_nettype wire

// ===== rtl/core/bte_ram.sv =====
`default_nettype none
module bte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire                                   clock,
   input  wire                                   wr_en,
   input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                      wr_data,
   input  wire                                   rd_en,
   input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;
endmodule
`default_nettype wire

// ===== rtl/core/bte_opq.sv =====
`default_nettype none
module bte_opq (
   input  wire             clock,
   input  wire             reset,
   input  wire             push,
   input  bte_pkg::op_type push_op,
   output logic            full,
   input  wire             pop,
   output bte_pkg::op_type pop_op,
   output logic            empty
);
   import bte_pkg::*;

   op_type                 slot_ff [OPQ_DEPTH];
   logic [OPQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OPQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OPQ_PTR_W:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == (OPQ_PTR_W+1)'(OPQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_op  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/bte_front.sv =====
`default_nettype none
module bte_front #(
   parameter int NUM_PINS = 32
) (
   input  wire              clock,
   input  wire              reset,
   input  bte_pkg::cfg_type cfg,
   input  wire              req_push,
   output logic             req_full,
   input  wire  [31:0]      req_changed_pins,
   input  wire  [31:0]      req_pin_levels,
   input  wire  [31:0]      req_tick_now,
   output logic             opq_push,
   output bte_pkg::op_type  opq_op,
   input  wire              opq_full
);
   import bte_pkg::*;

   localparam logic [PIN_W-1:0] LAST_PIN = PIN_W'(NUM_PINS - 1);

   fe_state_type      state_ff, state_in;
   logic [PIN_W-1:0]  pin_ff, pin_in;
   logic [WORD_W-1:0] hits_ff, hits_in;
   logic [WORD_W-1:0] levels_ff, levels_in;
   logic [WORD_W-1:0] tick_ff, tick_in;
   logic              accept, hit, released, advance;

   assign req_full = (state_ff != FE_IDLE);
   assign accept   = req_push && !req_full;
   assign hit      = hits_ff[pin_ff];
   assign released = (levels_ff[pin_ff] == cfg.active_low[pin_ff]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FE_IDLE: begin
            if (accept) state_in = FE_WALK;
         end
         FE_WALK: begin
            if (advance && pin_ff == LAST_PIN) state_in = FE_END;
         end
         FE_END: begin
            if (!opq_full) state_in = FE_IDLE;
         end
         default: state_in = FE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      advance       = 1'b0;
      opq_push      = 1'b0;
      opq_op.pin    = pin_ff;
      opq_op.tick   = tick_ff;
      opq_op.kind   = OP_END;
      case (state_ff)
         FE_WALK: begin
            opq_push = hit;
            advance  = !hit || !opq_full;
            if (cfg.report[pin_ff]) begin
               opq_op.kind = released ? OP_HELD : OP_STORE;
            end else begin
               opq_op.kind = released ? OP_RELEASE : OP_PRESS;
            end
         end
         FE_END: begin
            opq_push = 1'b1;
         end
         default: begin
            opq_push = 1'b0;
         end
      endcase
   end

   always_comb begin
      pin_in    = pin_ff;
      hits_in   = hits_ff;
      levels_in = levels_ff;
      tick_in   = tick_ff;
      if (accept) begin
         pin_in    = '0;
         hits_in   = req_changed_pins & cfg.enable;
         levels_in = req_pin_levels;
         tick_in   = req_tick_now;
      end else if (advance && pin_ff != LAST_PIN) begin
         pin_in = pin_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pin_ff    <= pin_in;
      hits_ff   <= hits_in;
      levels_ff <= levels_in;
      tick_ff   <= tick_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/bte_back.sv =====
`default_nettype none
module bte_back #(
   parameter int NUM_PINS = 32
) (
   input  wire             clock,
   input  wire             reset,
   input  wire             opq_empty,
   input  bte_pkg::op_type opq_op,
   output logic            opq_pop,
   output logic            rsp_empty,
   input  wire             rsp_pop,
   output logic [4:0]      rsp_button_index,
   output logic [1:0]      rsp_event_kind,
   output logic [31:0]     rsp_event_time,
   output logic            rsp_last_event
);
   import bte_pkg::*;

   localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

   bk_state_type      state_ff, state_in;
   logic [NUM_PINS-1:0] seen_ff;
   logic [PIN_W-1:0]  cur_pin_ff;
   logic [WORD_W-1:0] cur_tick_ff;
   logic              cand_end_ff;
   logic [PIN_W-1:0]  cand_pin_ff;
   logic [KIND_W-1:0] cand_kind_ff;
   logic [WORD_W-1:0] cand_time_ff;
   logic              pend_valid_ff;
   logic [PIN_W-1:0]  pend_pin_ff;
   logic [KIND_W-1:0] pend_kind_ff;
   logic [WORD_W-1:0] pend_time_ff;
   logic              out_valid_ff;
   logic [PIN_W-1:0]  out_pin_ff;
   logic [KIND_W-1:0] out_kind_ff;
   logic [WORD_W-1:0] out_time_ff;
   logic              out_last_ff;
   logic [IDX_W-1:0]  op_addr;
   logic [WORD_W-1:0] ram_rdata;
   logic              ram_we, ram_re, slot_free, take_op, take_read, commit, move_out;

   assign op_addr   = opq_op.pin[IDX_W-1:0];
   assign slot_free = !out_valid_ff || rsp_pop;

   bte_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_PINS)
   ) u_press_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (op_addr),
      .wr_data (opq_op.tick),
      .rd_en   (ram_re),
      .rd_addr (op_addr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!opq_empty) begin
               if (opq_op.kind inside {OP_PRESS, OP_RELEASE, OP_END}) begin
                  state_in = BK_EMIT;
               end else if (opq_op.kind == OP_HELD && seen_ff[op_addr]) begin
                  state_in = BK_READ;
               end
            end
         end
         BK_READ: begin
            // a press stored at tick zero reads as no press
            state_in = (ram_rdata != '0) ? BK_EMIT : BK_IDLE;
         end
         BK_EMIT: begin
            if (!pend_valid_ff || slot_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      opq_pop   = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      take_op   = 1'b0;
      take_read = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            opq_pop = !opq_empty;
            ram_we  = !opq_empty && opq_op.kind == OP_STORE;
            ram_re  = !opq_empty && opq_op.kind == OP_HELD && seen_ff[op_addr];
            take_op = !opq_empty && (opq_op.kind inside {OP_PRESS, OP_RELEASE, OP_END});
         end
         BK_READ: begin
            take_read = (ram_rdata != '0);
         end
         BK_EMIT: begin
            commit = !pend_valid_ff || slot_free;
         end
         default: begin
            opq_pop = 1'b0;
         end
      endcase
   end

   // the held result goes out once the next one, or the end of the request, is known
   assign move_out = commit && pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         seen_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ram_we) begin
            seen_ff[op_addr] <= 1'b1;
         end
         if (commit) begin
            pend_valid_ff <= !cand_end_ff;
         end
         if (move_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (ram_re) begin
         cur_pin_ff  <= opq_op.pin;
         cur_tick_ff <= opq_op.tick;
      end
      if (take_op) begin
         cand_end_ff  <= (opq_op.kind == OP_END);
         cand_pin_ff  <= opq_op.pin;
         cand_kind_ff <= (opq_op.kind == OP_RELEASE) ? KIND_RELEASE : KIND_PRESS;
         cand_time_ff <= opq_op.tick;
      end else if (take_read) begin
         cand_end_ff  <= 1'b0;
         cand_pin_ff  <= cur_pin_ff;
         cand_kind_ff <= KIND_HELD;
         cand_time_ff <= cur_tick_ff - ram_rdata;
      end
      if (commit && !cand_end_ff) begin
         pend_pin_ff  <= cand_pin_ff;
         pend_kind_ff <= cand_kind_ff;
         pend_time_ff <= cand_time_ff;
      end
      if (move_out) begin
         out_pin_ff  <= pend_pin_ff;
         out_kind_ff <= pend_kind_ff;
         out_time_ff <= pend_time_ff;
         out_last_ff <= cand_end_ff;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_button_index = out_pin_ff;
   assign rsp_event_kind   = out_kind_ff;
   assign rsp_event_time   = out_time_ff;
   assign rsp_last_event   = out_last_ff;
endmodule
`default_nettype wire

// ===== rtl/core/button_event_timestamper.sv =====
`default_nettype none
// channel  | direction | handshake           | payload
// req      | in        | req_push / req_full | changed_pins, pin_levels, tick_now
// rsp      | out       | rsp_pop / rsp_empty | button_index, event_kind, event_time, last_event
// csr      | in        | csr_valid/csr_ready | csr_index, csr_data
//
// the front walks NUM_PINS pins one per cycle, a full op queue stalls it at a pin with an op, and
// it takes no new request before all pins are walked and the end op is pushed
// a press or release passes back end idle, emit; a duration idle, press memory read, emit
// reset clears the valid bits of the press memory at once, no clearing pass
// a stalled rsp side backs up through the op queue into the front
module button_event_timestamper #(
   parameter int NUM_PINS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_push,
   output logic        req_full,
   input  wire  [31:0] req_changed_pins,
   input  wire  [31:0] req_pin_levels,
   input  wire  [31:0] req_tick_now,
   output logic        rsp_empty,
   input  wire         rsp_pop,
   output logic [4:0]  rsp_button_index,
   output logic [1:0]  rsp_event_kind,
   output logic [31:0] rsp_event_time,
   output logic        rsp_last_event,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [bte_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [31:0] csr_data
);
   import bte_pkg::*;

   cfg_type cfg_ff, cfg_in;
   op_type  push_op, pop_op;
   logic    opq_push, opq_full, opq_pop, opq_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE:     cfg_in.enable     = csr_data;
            CSR_ACTIVE_LOW: cfg_in.active_low = csr_data;
            CSR_REPORT:     cfg_in.report     = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bte_front #(
      .NUM_PINS (NUM_PINS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_changed_pins (req_changed_pins),
      .req_pin_levels   (req_pin_levels),
      .req_tick_now     (req_tick_now),
      .opq_push         (opq_push),
      .opq_op           (push_op),
      .opq_full         (opq_full)
   );

   bte_opq u_opq (
      .clock   (clock),
      .reset   (reset),
      .push    (opq_push),
      .push_op (push_op),
      .full    (opq_full),
      .pop     (opq_pop),
      .pop_op  (pop_op),
      .empty   (opq_empty)
   );

   bte_back #(
      .NUM_PINS (NUM_PINS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .opq_empty        (opq_empty),
      .opq_op           (pop_op),
      .opq_pop          (opq_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_button_index (rsp_button_index),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_time   (rsp_event_time),
      .rsp_last_event   (rsp_last_event)
   );
endmodule
`default_nettype wire
